/* hdl/edc_pkg.sv */
package edc_pkg;

  // mode codes carried in s_tuser
  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_STEP = 2'd1;
  localparam logic [1:0] MODE_END  = 2'd2;

  // width of the distance field on the output
  localparam int unsigned DIST_OUT_W = 5;
  localparam int unsigned DIST_SAT   = 31;

  // per-cell control from the top level
  typedef struct packed {
    logic clear;   // restore the row entry to its column index
    logic load;    // store a first-string byte in this cell
    logic active;  // column lies within the first string
  } cell_ctrl_t;

endpackage

/* hdl/edit_distance_engine.sv */
// Levenshtein distance engine. The first string is loaded one byte per word
// (mode 0) into a chain of MAX_LEN cells, one cell per byte, each holding its
// entry of the distance row. A second-string byte (mode 1) enters the chain as a
// wave that moves one cell per cycle, so mode 0 and mode 1 words are taken one per
// cycle while no end word is draining. An end word (mode 2) holds the input while the
// last wave runs off the end of the chain, then the distance and overflow flag
// are latched into the output register and the block is cleared for the next
// pair; a further end word waits if the previous result has not been taken.
// Bytes beyond MAX_LEN in either string are dropped and set the overflow flag;
// first-string bytes that arrive after second-string bytes are ignored.
module edit_distance_engine #(
  parameter int unsigned MAX_LEN = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] symbol
  input  logic [1:0] s_tuser,   // [1:0] mode
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [4:0] distance, [7:5] zero
  output logic       m_tuser    // [0] overflow
);

  localparam int unsigned DW = (MAX_LEN < 2) ? 1 : $clog2(MAX_LEN + 1);
  localparam int unsigned EW = (DW > edc_pkg::DIST_OUT_W) ? DW : edc_pkg::DIST_OUT_W;

  typedef enum logic {S_IDLE, S_DRAIN} state_t;

  state_t        state;
  logic [DW-1:0] cnt;
  logic [DW-1:0] first_len;
  logic [DW-1:0] second_len;
  logic          overflow_flag;
  logic          accept;
  logic          drain_done;
  logic [DW-1:0] sel_dist;
  logic [EW-1:0] ext_dist;
  logic [edc_pkg::DIST_OUT_W-1:0] distance;

  logic          wv_valid [0:MAX_LEN];
  logic [7:0]    wv_sym   [0:MAX_LEN];
  logic [DW-1:0] wv_new   [0:MAX_LEN];
  logic [DW-1:0] wv_old   [0:MAX_LEN];
  logic [DW-1:0] cell_dist [1:MAX_LEN];
  logic [DW-1:0] tap      [0:MAX_LEN];
  edc_pkg::cell_ctrl_t ctrl [1:MAX_LEN];

  assign s_tready   = (state == S_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign drain_done = (state == S_DRAIN) && (cnt == '0) && (!m_tvalid || m_tready);

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (drain_done) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && s_tuser == edc_pkg::MODE_END) begin
            state <= S_DRAIN;
            cnt   <= DW'(MAX_LEN);
          end
        end
        S_DRAIN: begin
          if (cnt != '0) begin
            cnt <= cnt - DW'(1);
          end else if (drain_done) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (drain_done) begin
      m_tdata <= {{(8 - edc_pkg::DIST_OUT_W){1'b0}}, distance};
      m_tuser <= overflow_flag;
    end
  end

  // string lengths and overflow flag
  always_ff @(posedge clk) begin
    if (rst || drain_done) begin
      first_len     <= '0;
      second_len    <= '0;
      overflow_flag <= 1'b0;
    end else if (accept) begin
      if (s_tuser == edc_pkg::MODE_LOAD && second_len == '0) begin
        if (first_len < DW'(MAX_LEN)) begin
          first_len <= first_len + DW'(1);
        end else begin
          overflow_flag <= 1'b1;
        end
      end else if (s_tuser == edc_pkg::MODE_STEP) begin
        if (second_len < DW'(MAX_LEN)) begin
          second_len <= second_len + DW'(1);
        end else begin
          overflow_flag <= 1'b1;
        end
      end
    end
  end

  // head of the chain: injects a wave with the boundary column
  always_ff @(posedge clk) begin
    if (rst || drain_done) begin
      wv_valid[0] <= 1'b0;
    end else begin
      wv_valid[0] <= accept && s_tuser == edc_pkg::MODE_STEP && second_len < DW'(MAX_LEN);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      wv_sym[0] <= s_tdata;
      wv_old[0] <= second_len;
      wv_new[0] <= second_len + DW'(1);
    end
  end

  // the cell chain
  for (genvar i = 1; i <= MAX_LEN; i++) begin : g_cell
    always_comb begin
      ctrl[i].clear  = drain_done;
      ctrl[i].load   = accept && s_tuser == edc_pkg::MODE_LOAD && second_len == '0
                       && first_len == DW'(i - 1);
      ctrl[i].active = (DW'(i) <= first_len);
    end

    edc_cell #(.IDX(i), .DW(DW)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl[i]),
      .load_sym  (s_tdata),
      .in_valid  (wv_valid[i-1]),
      .in_sym    (wv_sym[i-1]),
      .in_new    (wv_new[i-1]),
      .in_old    (wv_old[i-1]),
      .out_valid (wv_valid[i]),
      .out_sym   (wv_sym[i]),
      .out_new   (wv_new[i]),
      .out_old   (wv_old[i]),
      .entry     (cell_dist[i])
    );

    assign tap[i] = (first_len == DW'(i)) ? cell_dist[i] : '0;
  end

  // pick the row entry at the end of the first string
  assign tap[0] = (first_len == '0) ? second_len : '0;

  always_comb begin
    sel_dist = '0;
    for (int k = 0; k <= MAX_LEN; k++) begin
      sel_dist = sel_dist | tap[k];
    end
    ext_dist = EW'(sel_dist);
    distance = (ext_dist > EW'(edc_pkg::DIST_SAT)) ? edc_pkg::DIST_OUT_W'(edc_pkg::DIST_SAT)
                                                   : ext_dist[edc_pkg::DIST_OUT_W-1:0];
  end

  // an end word closes the input until the result is latched
  a_end_blocks: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser == edc_pkg::MODE_END) |=> !s_tready)
    else $error("input not held after end word");

  // the chain is empty once the result has been latched
  a_drained: assert property (@(posedge clk) disable iff (rst)
    drain_done |=> !wv_valid[MAX_LEN])
    else $error("wave still in chain after result");

  // a finished pair leaves the block cleared
  a_cleared: assert property (@(posedge clk) disable iff (rst)
    drain_done |=> (first_len == '0 && second_len == '0 && !overflow_flag))
    else $error("block not cleared after result");

  // the selected distance never exceeds MAX_LEN
  a_bound: assert property (@(posedge clk) disable iff (rst)
    drain_done |-> (ext_dist <= EW'(MAX_LEN)))
    else $error("distance beyond string length");

endmodule

/* hdl/edc_cell.sv */
module edc_cell #(
  parameter int unsigned IDX = 1,
  parameter int unsigned DW  = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  edc_pkg::cell_ctrl_t   ctrl,
  input  logic [7:0]            load_sym,
  input  logic                  in_valid,
  input  logic [7:0]            in_sym,
  input  logic [DW-1:0]         in_new,
  input  logic [DW-1:0]         in_old,
  output logic                  out_valid,
  output logic [7:0]            out_sym,
  output logic [DW-1:0]         out_new,
  output logic [DW-1:0]         out_old,
  output logic [DW-1:0]         entry
);

  logic [7:0]  ch;
  logic [DW:0] sub_cost;
  logic [DW:0] up_cost;
  logic [DW:0] left_cost;
  logic [DW:0] best;
  logic [DW-1:0] dist_next;

  // one row entry: min of diagonal plus mismatch, above plus one, left plus one
  always_comb begin
    sub_cost  = {1'b0, in_old} + ((ch != in_sym) ? (DW+1)'(1) : (DW+1)'(0));
    up_cost   = {1'b0, entry} + (DW+1)'(1);
    left_cost = {1'b0, in_new} + (DW+1)'(1);
    best      = (up_cost < left_cost) ? up_cost : left_cost;
    if (sub_cost < best) begin
      best = sub_cost;
    end
    dist_next = best[DW-1:0];
  end

  // stored byte of the first string
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      ch <= load_sym;
    end
  end

  // row entry and the wave handed to the right neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      entry     <= DW'(IDX);
    end else if (ctrl.clear) begin
      out_valid <= 1'b0;
      entry     <= DW'(IDX);
    end else begin
      out_valid <= in_valid;
      if (in_valid && ctrl.active) begin
        entry <= dist_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      out_sym <= in_sym;
      out_new <= dist_next;
      out_old <= entry;
    end
  end

endmodule

/* tb/edit_distance_engine_test.sv */
`timescale 1ns / 1ps

module edit_distance_engine_test;

  localparam int unsigned MAX_LEN     = 16;
  localparam logic [1:0]  MODE_SPARE  = 2'd3;
  localparam int unsigned WORD_TARGET = 650;
  localparam int unsigned MAX_GAP     = 17;
  localparam int unsigned CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic [edc_pkg::DIST_OUT_W-1:0] distance;
    logic                           overflow;
  } pair_result_t;

  // running levenshtein row plus the queue of distances still owed by the block
  class distance_scoreboard;
    logic [7:0]   first_bytes[MAX_LEN];
    int unsigned  row[MAX_LEN+1];
    int unsigned  first_len;
    int unsigned  second_len;
    bit           overflow_seen;
    pair_result_t owed_q[$];
    int unsigned  errors;

    function new();
      errors = 0;
      clear_pair();
    endfunction

    function void clear_pair();
      for (int k = 0; k <= MAX_LEN; k++) row[k] = k;
      first_len     = 0;
      second_len    = 0;
      overflow_seen = 1'b0;
    endfunction

    task report(string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      errors++;
    endtask

    // one second-string byte moves the row down by one
    function void advance_row(logic [7:0] sym);
      int unsigned diag, above, sub, gap;
      diag = row[0];
      row[0] = second_len + 1;
      for (int i = 1; i <= first_len; i++) begin
        above = row[i];
        sub = diag + ((first_bytes[i-1] == sym) ? 0 : 1);
        gap = ((above < row[i-1]) ? above : row[i-1]) + 1;
        row[i] = (sub < gap) ? sub : gap;
        diag = above;
      end
      second_len++;
    endfunction

    // accepted input word
    function void note_word(logic [1:0] mode, logic [7:0] sym);
      pair_result_t res;
      int unsigned d;
      case (mode)
        edc_pkg::MODE_LOAD: begin
          // first-string bytes after the second string has started are dropped
          if (second_len == 0) begin
            if (first_len < MAX_LEN) begin
              first_bytes[first_len] = sym;
              first_len++;
            end else begin
              overflow_seen = 1'b1;
            end
          end
        end
        edc_pkg::MODE_STEP: begin
          if (second_len < MAX_LEN) advance_row(sym);
          else overflow_seen = 1'b1;
        end
        edc_pkg::MODE_END: begin
          d = row[first_len];
          if (d > edc_pkg::DIST_SAT) d = edc_pkg::DIST_SAT;
          res.distance = d[edc_pkg::DIST_OUT_W-1:0];
          res.overflow = overflow_seen;
          owed_q = {owed_q, res};
          clear_pair();
        end
        default: ;
      endcase
    endfunction

    // accepted output word
    task check_result(logic [edc_pkg::DIST_OUT_W-1:0] distance, logic overflow);
      pair_result_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("unexpected result distance %0d overflow %0b", distance, overflow));
        return;
      end
      want = owed_q.pop_front();
      if (distance !== want.distance)
        report($sformatf("distance %0d, want %0d", distance, want.distance));
      if (overflow !== want.overflow)
        report($sformatf("overflow %0b, want %0b", overflow, want.overflow));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic [1:0] s_tuser = edc_pkg::MODE_LOAD;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tuser;

  distance_scoreboard sb;
  int unsigned        cycles = 0;
  int unsigned        words_sent = 0;
  bit                 send_burst = 1'b0;

  edit_distance_engine #(.MAX_LEN(MAX_LEN)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #6 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("edit_distance_engine verification failed");
      $finish;
    end
  end

  // one input word, after a random gap unless in a burst
  task automatic send_word(input logic [1:0] mode, input logic [7:0] sym);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom);
      s_tuser  <= 2'($urandom);
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= sym;
    s_tuser  <= mode;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_word(mode, sym);
  endtask

  function automatic logic [7:0] pick_symbol(logic [7:0] base, bit narrow);
    return narrow ? (base ^ 8'($urandom_range(0, 3))) : 8'($urandom);
  endfunction

  // one string pair; narrow symbols give frequent matches, noisy adds ignored words
  task automatic send_pair(int unsigned n_first, int unsigned n_second, bit narrow, bit noisy);
    logic [7:0] base;
    base = 8'($urandom);
    send_burst = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n_first; i++) begin
      send_word(edc_pkg::MODE_LOAD, pick_symbol(base, narrow));
      words_sent++;
      if (noisy && $urandom_range(0, 3) == 0) send_word(MODE_SPARE, 8'($urandom));
    end
    for (int i = 0; i < n_second; i++) begin
      send_word(edc_pkg::MODE_STEP, pick_symbol(base, narrow));
      words_sent++;
      if (noisy && $urandom_range(0, 2) == 0)
        send_word($urandom_range(0, 1) ? edc_pkg::MODE_LOAD : MODE_SPARE, 8'($urandom));
    end
    send_word(edc_pkg::MODE_END, 8'($urandom));
    words_sent++;
  endtask

  // result side, with its own random stalls and stretches without them
  task automatic run_receiver();
    int unsigned stall;
    int unsigned left_in_stretch;
    bit          rx_burst;
    rx_burst = 1'b0;
    left_in_stretch = 0;
    forever begin
      if (left_in_stretch == 0) begin
        rx_burst = ($urandom_range(0, 2) == 0);
        left_in_stretch = $urandom_range(1, 6);
      end
      left_in_stretch--;
      stall = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      sb.check_result(m_tdata[edc_pkg::DIST_OUT_W-1:0], m_tuser);
    end
  endtask

  initial begin
    int unsigned kind;
    int unsigned n1;
    int unsigned n2;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    fork
      run_receiver();
    join_none

    // empty pair
    send_word(edc_pkg::MODE_END, 8'h00);
    // one deletion at the byte extremes
    send_word(edc_pkg::MODE_LOAD, 8'h00);
    send_word(edc_pkg::MODE_LOAD, 8'hFF);
    send_word(edc_pkg::MODE_STEP, 8'hFF);
    send_word(edc_pkg::MODE_END, 8'hFF);
    // empty first string, unused mode in between
    send_word(edc_pkg::MODE_STEP, 8'h80);
    send_word(MODE_SPARE, 8'h55);
    send_word(edc_pkg::MODE_STEP, 8'h7F);
    send_word(edc_pkg::MODE_END, 8'hAA);
    // late first-string byte is ignored
    send_word(edc_pkg::MODE_LOAD, 8'h5A);
    send_word(edc_pkg::MODE_STEP, 8'h5A);
    send_word(edc_pkg::MODE_LOAD, 8'h11);
    send_word(edc_pkg::MODE_END, 8'h00);
    // reversed string
    send_word(edc_pkg::MODE_LOAD, 8'h01);
    send_word(edc_pkg::MODE_LOAD, 8'h02);
    send_word(edc_pkg::MODE_LOAD, 8'h03);
    send_word(edc_pkg::MODE_STEP, 8'h03);
    send_word(edc_pkg::MODE_STEP, 8'h02);
    send_word(edc_pkg::MODE_STEP, 8'h01);
    send_word(edc_pkg::MODE_END, 8'h00);

    // random pairs, mostly short and well formed
    while (words_sent < WORD_TARGET) begin
      kind = $urandom_range(0, 19);
      if (kind < 12) begin
        n1 = $urandom_range(0, 6);
        n2 = $urandom_range(0, 6);
        send_pair(n1, n2, 1'($urandom_range(0, 1)), kind < 2);
      end else if (kind < 15) begin
        n1 = $urandom_range(0, MAX_LEN);
        n2 = $urandom_range(0, MAX_LEN);
        send_pair(n1, n2, 1'($urandom_range(0, 1)), 1'b0);
      end else if (kind < 17) begin
        // a string near or beyond MAX_LEN on either side
        n1 = $urandom_range(MAX_LEN - 1, MAX_LEN + 2);
        n2 = $urandom_range(0, MAX_LEN + 2);
        if ($urandom_range(0, 1)) send_pair(n1, n2, 1'b1, 1'b0);
        else send_pair(n2, n1, 1'b1, 1'b0);
      end else if (kind == 17) begin
        send_pair(MAX_LEN, MAX_LEN, 1'($urandom_range(0, 1)), 1'b0);
      end else begin
        n1 = $urandom_range(0, 8);
        n2 = $urandom_range(1, 8);
        send_pair(n1, n2, 1'b1, 1'b1);
      end
    end
    s_tvalid <= 1'b0;

    // drain, then leave room for any stray result
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (2 * MAX_LEN + 8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("edit_distance_engine verification clean");
    end else begin
      $display("edit_distance_engine verification failed");
    end
    $finish;
  end

endmodule
